FILE: hw/rtl/lcmf_pkg.sv
// shared types and constants for the load-cell median / dual-ema motion filter
// no dependencies; imported by every module of the block
package lcmf_pkg;

  // sample path
  localparam int SAMPLE_BITS  = 24;
  localparam int MEDIAN_TAPS  = 5;
  localparam int MED_RANK     = MEDIAN_TAPS / 2;
  localparam int TAP_IDX_W    = $clog2(MEDIAN_TAPS);
  localparam int FILL_W       = $clog2(MEDIAN_TAPS + 1);
  localparam int RANK_W       = $clog2(MEDIAN_TAPS);

  // port widths fixed by the interface
  localparam int SAMPLE_IN_W  = 24;
  localparam int MEDIAN_OUT_W = 24;
  localparam int TIME_W       = 32;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_IDX_W    = 2;

  // levels and blend arithmetic
  localparam int LEVEL_W      = 32;
  localparam int LEVEL_FRAC   = 8;
  localparam int COEF_W       = 16;
  localparam int COEF_CNT_W   = $clog2(COEF_W);
  localparam int DELTA_W      = LEVEL_W + 1;
  localparam int ACC_W        = LEVEL_W + 2;

  // q0.16 weights of the new value, rounded half up
  localparam logic [COEF_W-1:0] W_FAST         = 16'd22938;
  localparam logic [COEF_W-1:0] W_SLOW         = 16'd5243;
  localparam logic [COEF_W-1:0] W_DISP_SETTLED = 16'd13107;
  localparam logic [COEF_W-1:0] W_DISP_NEITHER = 16'd9830;

  // configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0]  REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_DELAY     = 2'd1;
  localparam logic [CFG_DATA_W-1:0] THRESHOLD_RST = 16'd120;
  localparam logic [CFG_DATA_W-1:0] DELAY_RST     = 16'd700;

  // input kind codes
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TARE   = 1'b1;

  typedef struct packed {
    logic                start;
    logic [LEVEL_W-1:0]  base;
    logic [LEVEL_W-1:0]  target;
    logic [COEF_W-1:0]   weight;
  } blend_req_t;

  typedef struct packed {
    logic                done;
    logic [DELTA_W-1:0]  delta;
  } blend_rsp_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic search;
  } med_ctl_t;

  typedef struct packed {
    logic done;
    logic full;
  } med_rsp_t;

endpackage

FILE: hw/rtl/lcmf_median.sv
// sample history shift line and rank-search median unit
// depends on lcmf_pkg
module lcmf_median import lcmf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  med_ctl_t               ctl,
  input  logic [SAMPLE_BITS-1:0] push_data,
  output med_rsp_t               rsp,
  output logic [SAMPLE_BITS-1:0] median
);

  logic [SAMPLE_BITS-1:0] hist_r [MEDIAN_TAPS];
  logic [FILL_W-1:0]      fill_r;
  logic [TAP_IDX_W-1:0]   cnt_r;
  logic                   busy_r;
  logic                   done_r;
  logic                   found_r;
  logic [SAMPLE_BITS-1:0] median_r;

  logic [RANK_W-1:0]      less_cnt;
  logic [RANK_W-1:0]      eq_cnt;
  logic                   qualifies;

  // candidate sits at tap 0; count how the other taps rank against it
  always_comb begin
    less_cnt = '0;
    eq_cnt   = '0;
    for (int j = 1; j < MEDIAN_TAPS; j++) begin
      if ($signed(hist_r[j]) < $signed(hist_r[0])) begin
        less_cnt = less_cnt + RANK_W'(1);
      end
      if (hist_r[j] == hist_r[0]) begin
        eq_cnt = eq_cnt + RANK_W'(1);
      end
    end
    qualifies = (less_cnt <= RANK_W'(MED_RANK)) &&
                (({1'b0, less_cnt} + {1'b0, eq_cnt}) >= (RANK_W + 1)'(MED_RANK));
  end

  // history: shift in on push, rotate once per search step
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      hist_r[0] <= push_data;
      for (int i = 1; i < MEDIAN_TAPS; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end else if (busy_r) begin
      hist_r[MEDIAN_TAPS-1] <= hist_r[0];
      for (int i = 0; i < MEDIAN_TAPS - 1; i++) begin
        hist_r[i] <= hist_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      cnt_r   <= '0;
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.clear) begin
        fill_r <= '0;
      end else if (ctl.push && (fill_r != FILL_W'(MEDIAN_TAPS))) begin
        fill_r <= fill_r + FILL_W'(1);
      end
      if (ctl.search) begin
        busy_r  <= 1'b1;
        cnt_r   <= '0;
        found_r <= 1'b0;
      end else if (busy_r) begin
        if (qualifies && !found_r) begin
          found_r <= 1'b1;
        end
        cnt_r <= cnt_r + TAP_IDX_W'(1);
        if (cnt_r == TAP_IDX_W'(MEDIAN_TAPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r && qualifies && !found_r) begin
      median_r <= hist_r[0];
    end
  end

  assign rsp.done = done_r;
  assign rsp.full = (fill_r == FILL_W'(MEDIAN_TAPS));
  assign median   = median_r;

endmodule

FILE: hw/rtl/lcmf_blend.sv
// bit-serial blend unit: delta = floor(((target - base) * weight + 2^15) / 2^16)
// one weight bit per cycle; depends on lcmf_pkg
module lcmf_blend import lcmf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  blend_req_t req,
  output blend_rsp_t rsp
);

  logic signed [DELTA_W-1:0] d_r;
  logic        [COEF_W-1:0]  w_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic        [COEF_W-1:0]  lo_r;
  logic [COEF_CNT_W-1:0]     cnt_r;
  logic                      busy_r;
  logic                      done_r;

  logic signed [ACC_W-1:0]   addend;
  logic signed [ACC_W-1:0]   sum;
  logic signed [ACC_W-1:0]   rounded;

  assign addend  = w_r[0] ? ACC_W'(d_r) : '0;
  assign sum     = acc_r + addend;
  // low half of the product decides the half-up rounding
  assign rounded = acc_r + $signed({{(ACC_W-1){1'b0}}, lo_r[COEF_W-1]});

  always_ff @(posedge clk) begin
    if (req.start) begin
      d_r   <= DELTA_W'($signed(req.target)) - DELTA_W'($signed(req.base));
      w_r   <= req.weight;
      acc_r <= '0;
      lo_r  <= '0;
    end else if (busy_r) begin
      acc_r <= sum >>> 1;
      lo_r  <= {sum[0], lo_r[COEF_W-1:1]};
      w_r   <= {1'b0, w_r[COEF_W-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + COEF_CNT_W'(1);
        if (cnt_r == COEF_CNT_W'(COEF_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done  = done_r;
  assign rsp.delta = rounded[DELTA_W-1:0];

endmodule

FILE: hw/rtl/load_cell_median_ema_motion_filter_top.sv
// Load-cell filter: five-tap median, fast/slow ema, motion and settle flags, display level.
// The median search rotates the history once, one tap per cycle, then the level is loaded.
// Two bit-serial blend units then run the fast and slow ema side by side. Unless the weight
// is moving, one of them then runs the display blend. Then the output register is loaded.
// While the history fills, the median search is skipped. The first sample after reset or
// tare loads the levels without a blend, and a tare goes straight to the output register.
// One transaction is in work at a time. The input is stalled from acceptance until the
// result is loaded. The finished result waits in the output register while the next
// transaction is accepted. Levels are signed q.8. Depends on lcmf_pkg, lcmf_median and
// lcmf_blend.
module load_cell_median_ema_motion_filter_top import lcmf_pkg::*; (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_kind,
  input  logic signed [SAMPLE_IN_W-1:0]  in_sample,
  input  logic        [TIME_W-1:0]       in_now_ms,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [MEDIAN_OUT_W-1:0] out_median_value,
  output logic signed [LEVEL_W-1:0]      out_fast_value,
  output logic signed [LEVEL_W-1:0]      out_slow_value,
  output logic signed [LEVEL_W-1:0]      out_display_value,
  output logic                           out_moving,
  output logic                           out_settled,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_MED, S_LEVEL, S_EMA, S_DSTART, S_DISP, S_OUT
  } state_t;

  state_t                     state_r;
  logic [CFG_DATA_W-1:0]      thr_r;
  logic [CFG_DATA_W-1:0]      delay_r;
  logic [SAMPLE_BITS-1:0]     med_val_r;
  logic [TIME_W-1:0]          now_r;
  logic [TIME_W-1:0]          last_r;
  logic signed [LEVEL_W-1:0]  fast_r;
  logic signed [LEVEL_W-1:0]  slow_r;
  logic signed [LEVEL_W-1:0]  shown_r;
  logic                       primed_r;
  logic                       moving_r;
  logic                       settled_r;

  logic                            out_valid_r;
  logic signed [MEDIAN_OUT_W-1:0]  out_median_r;
  logic signed [LEVEL_W-1:0]       out_fast_r;
  logic signed [LEVEL_W-1:0]       out_slow_r;
  logic signed [LEVEL_W-1:0]       out_display_r;
  logic                            out_moving_r;
  logic                            out_settled_r;

  med_ctl_t               med_ctl;
  med_rsp_t               med_rsp;
  logic [SAMPLE_BITS-1:0] med_value;
  blend_req_t             req0;
  blend_req_t             req1;
  blend_rsp_t             rsp0;
  blend_rsp_t             rsp1;

  logic                       in_take;
  logic signed [LEVEL_W-1:0]  level;
  logic signed [DELTA_W-1:0]  step;
  logic        [DELTA_W-1:0]  step_mag;
  logic                       motion;
  logic                       quiet;
  logic signed [LEVEL_W-1:0]  fast_new;

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  assign med_ctl.clear  = in_take && (in_kind == KIND_TARE);
  assign med_ctl.push   = in_take && (in_kind == KIND_SAMPLE);
  assign med_ctl.search = (state_r == S_PREP) && med_rsp.full;

  lcmf_median u_median (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (med_ctl),
    .push_data (in_sample[SAMPLE_BITS-1:0]),
    .rsp       (med_rsp),
    .median    (med_value)
  );

  assign level = LEVEL_W'($signed(med_val_r)) <<< LEVEL_FRAC;

  // unit 0 does the fast ema, then the display blend
  always_comb begin
    req0.start  = ((state_r == S_LEVEL) && primed_r) || (state_r == S_DSTART);
    req0.base   = (state_r == S_DSTART) ? shown_r : fast_r;
    req0.target = (state_r == S_DSTART) ? slow_r : level;
    if (state_r == S_DSTART) begin
      req0.weight = settled_r ? W_DISP_SETTLED : W_DISP_NEITHER;
    end else begin
      req0.weight = W_FAST;
    end
    req1.start  = (state_r == S_LEVEL) && primed_r;
    req1.base   = slow_r;
    req1.target = level;
    req1.weight = W_SLOW;
  end

  lcmf_blend u_blend_fast (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req0),
    .rsp   (rsp0)
  );

  lcmf_blend u_blend_slow (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req1),
    .rsp   (rsp1)
  );

  // the fast-level step equals the blend delta
  assign step     = $signed(rsp0.delta);
  assign step_mag = step[DELTA_W-1] ? DELTA_W'(-step) : DELTA_W'(step);
  assign motion   = step_mag > (DELTA_W'(thr_r) << LEVEL_FRAC);
  assign quiet    = TIME_W'(now_r - last_r) > TIME_W'(delay_r);
  assign fast_new = fast_r + LEVEL_W'(step);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      thr_r       <= THRESHOLD_RST;
      delay_r     <= DELAY_RST;
      last_r      <= '0;
      fast_r      <= '0;
      slow_r      <= '0;
      shown_r     <= '0;
      primed_r    <= 1'b0;
      moving_r    <= 1'b0;
      settled_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_THRESHOLD) begin
          thr_r <= cfg_data;
        end else if (cfg_index == REG_DELAY) begin
          delay_r <= cfg_data;
        end
      end
      if ((state_r == S_OUT) && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            now_r <= in_now_ms;
            if (in_kind == KIND_TARE) begin
              med_val_r <= '0;
              last_r    <= in_now_ms;
              fast_r    <= '0;
              slow_r    <= '0;
              shown_r   <= '0;
              primed_r  <= 1'b0;
              moving_r  <= 1'b0;
              settled_r <= 1'b0;
              state_r   <= S_OUT;
            end else begin
              med_val_r <= in_sample[SAMPLE_BITS-1:0];
              state_r   <= S_PREP;
            end
          end
        end
        S_PREP: begin
          state_r <= med_rsp.full ? S_MED : S_LEVEL;
        end
        S_MED: begin
          if (med_rsp.done) begin
            med_val_r <= med_value;
            state_r   <= S_LEVEL;
          end
        end
        S_LEVEL: begin
          if (!primed_r) begin
            fast_r   <= level;
            slow_r   <= level;
            shown_r  <= level;
            last_r   <= now_r;
            primed_r <= 1'b1;
            state_r  <= S_OUT;
          end else begin
            state_r <= S_EMA;
          end
        end
        S_EMA: begin
          if (rsp0.done) begin
            fast_r <= fast_new;
            slow_r <= slow_r + LEVEL_W'($signed(rsp1.delta));
            if (motion) begin
              last_r    <= now_r;
              moving_r  <= 1'b1;
              settled_r <= 1'b0;
              shown_r   <= fast_new;
              state_r   <= S_OUT;
            end else begin
              moving_r  <= 1'b0;
              settled_r <= quiet;
              state_r   <= S_DSTART;
            end
          end
        end
        S_DSTART: begin
          state_r <= S_DISP;
        end
        S_DISP: begin
          if (rsp0.done) begin
            shown_r <= shown_r + LEVEL_W'($signed(rsp0.delta));
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_median_r  <= MEDIAN_OUT_W'($signed(med_val_r));
            out_fast_r    <= fast_r;
            out_slow_r    <= slow_r;
            out_display_r <= shown_r;
            out_moving_r  <= moving_r;
            out_settled_r <= settled_r;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_median_value  = out_median_r;
  assign out_fast_value    = out_fast_r;
  assign out_slow_value    = out_slow_r;
  assign out_display_value = out_display_r;
  assign out_moving        = out_moving_r;
  assign out_settled       = out_settled_r;

  // both ema units are started together and must finish together
  a_blend_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    rsp1.done |-> (rsp0.done && (state_r == S_EMA)))
    else $error("slow ema finished out of step with fast ema");

  // a median result only shows up while the fsm waits for it
  a_median_owner: assert property (@(posedge clk) disable iff (!rst_n)
    med_rsp.done |-> (state_r == S_MED))
    else $error("median search finished outside its wait state");

  // a new result is only published from the output state
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_OUT))
    else $error("result published outside the output state");

  // an accepted transaction holds off the next one
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second transaction accepted while one is in work");

endmodule
